// File: design/dedq_pkg.sv
package dedq_pkg;

	localparam int CNT_W  = 5;
	localparam int WORD_W = 32;

	// operation codes
	typedef enum logic [2:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_REAR  = 3'd1,
		KIND_DEL_FRONT = 3'd2,
		KIND_DEL_REAR  = 3'd3,
		KIND_QUERY     = 3'd4
	} kind_t;

	// register byte offsets
	localparam logic [2:0] REG_CAPACITY = 3'd0;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		kind_t                     kind;
		logic signed [WORD_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic                      ok;
		logic signed [WORD_W-1:0]  front_value;
		logic signed [WORD_W-1:0]  rear_value;
		logic                      empty_res;
		logic                      full_res;
		logic [CNT_W-1:0]          occupancy;
	} res_t;

	// status of one operation, after the update
	typedef struct packed {
		logic             ok;
		logic             empty;
		logic             full;
		logic [CNT_W-1:0] occupancy;
	} stat_t;

endpackage

// File: design/dedq_ram.sv
module dedq_ram #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [dedq_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [dedq_pkg::WORD_W-1:0] rdata_a,
	output logic [dedq_pkg::WORD_W-1:0] rdata_b
);
	import dedq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports, old data on a same-cycle write
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: design/dedq_ptr.sv
module dedq_ptr #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        clear,
	input  dedq_pkg::cmd_t              cmd,
	input  logic [dedq_pkg::CNT_W-1:0]  cap,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [dedq_pkg::WORD_W-1:0] mem_wdata,
	output logic [AW-1:0]               raddr_front,
	output logic [AW-1:0]               raddr_rear,
	output dedq_pkg::stat_t             status
);
	import dedq_pkg::*;

	localparam int PW = ((AW > CNT_W) ? AW : CNT_W) + 1;

	logic [AW-1:0]    head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    head_nx, tail_nx;
	logic [CNT_W-1:0] count_nx;
	logic             ok;
	logic             full, empty;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx,
			input logic [CNT_W-1:0] c);
		logic [PW-1:0] nx;
		nx = PW'(idx) + PW'(1);
		return (nx >= PW'(c)) ? '0 : nx[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx,
			input logic [CNT_W-1:0] c);
		logic [PW-1:0] last;
		last = PW'(c) - PW'(1);
		return (idx == '0 || PW'(idx) > PW'(c)) ? last[AW-1:0] : idx - 1'b1;
	endfunction

	assign full  = (count_q >= cap);
	assign empty = (count_q == '0);

	// next pointers, count and memory write for the requested operation
	always_comb begin
		head_nx   = head_q;
		tail_nx   = tail_q;
		count_nx  = count_q;
		ok        = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = cmd.value;
		case (cmd.kind)
			KIND_INS_FRONT: begin
				if (!full) begin
					head_nx   = ring_dec(head_q, cap);
					mem_we    = accept;
					mem_waddr = head_nx;
					count_nx  = count_q + 1'b1;
					ok        = 1'b1;
				end
			end
			KIND_INS_REAR: begin
				if (!full) begin
					mem_we    = accept;
					mem_waddr = tail_q;
					tail_nx   = ring_inc(tail_q, cap);
					count_nx  = count_q + 1'b1;
					ok        = 1'b1;
				end
			end
			KIND_DEL_FRONT: begin
				if (!empty) begin
					head_nx  = ring_inc(head_q, cap);
					count_nx = count_q - 1'b1;
					ok       = 1'b1;
				end
			end
			KIND_DEL_REAR: begin
				if (!empty) begin
					tail_nx  = ring_dec(tail_q, cap);
					count_nx = count_q - 1'b1;
					ok       = 1'b1;
				end
			end
			KIND_QUERY: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// read addresses of the front and rear after the update
	assign raddr_front = head_nx;
	assign raddr_rear  = ring_dec(tail_nx, cap);

	always_comb begin
		status.ok        = ok;
		status.empty     = (count_nx == '0);
		status.full      = (count_nx >= cap);
		status.occupancy = count_nx;
	end

	// pointer and count registers, emptied by a capacity write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			count_q <= count_nx;
		end
	end

endmodule

// File: design/double_ended_ring_queue.sv
// channel   direction  handshake                       payload
// command   in         start & !busy                   cmd (cmd_t)
// result    out        done, one cycle, no back-press  result (res_t)
// config    in         psel & penable & pwrite         pwdata[4:0] at paddr 0
//
// One command is taken every cycle; busy stays low. The result appears in the
// cycle after the command, set by the registered read of the storage memory;
// a word written by the same command is forwarded past the memory.
// Reset clears pointers and count and sets capacity to 16; storage keeps no
// reset value. A capacity write empties the queue.
module double_ended_ring_queue #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dedq_pkg::cmd_t      cmd,
	output logic                done,
	output dedq_pkg::res_t      result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import dedq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  cap_eff;
	logic              cfg_wr;
	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [AW-1:0]     raddr_front, raddr_rear;
	logic [WORD_W-1:0] rdata_front, rdata_rear;
	stat_t             status;
	stat_t             stat_s1;
	logic              done_s1;
	logic              fwd_front_s1, fwd_rear_s1;
	logic [WORD_W-1:0] wdata_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY[2]) ? {{(32-CNT_W){1'b0}}, capacity_q} : '0;

	// effective capacity, clamped to one and to the ring size
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = capacity_q;
		end
	end

	dedq_ptr #(.DEPTH(DEPTH)) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.clear      (cfg_wr),
		.cmd        (cmd),
		.cap        (cap_eff),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.raddr_front(raddr_front),
		.raddr_rear (raddr_rear),
		.status     (status)
	);

	dedq_ram #(.DEPTH(DEPTH)) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(raddr_front),
		.raddr_b(raddr_rear),
		.rdata_a(rdata_front),
		.rdata_b(rdata_rear)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// status and write forwarding alongside the memory read
	always_ff @(posedge clk) begin
		stat_s1      <= status;
		fwd_front_s1 <= mem_we && (mem_waddr == raddr_front);
		fwd_rear_s1  <= mem_we && (mem_waddr == raddr_rear);
		wdata_s1     <= mem_wdata;
	end

	// result assembly
	assign done = done_s1;

	always_comb begin
		result.ok          = stat_s1.ok;
		result.empty_res   = stat_s1.empty;
		result.full_res    = stat_s1.full;
		result.occupancy   = stat_s1.occupancy;
		result.front_value = stat_s1.empty ? '1 : (fwd_front_s1 ? wdata_s1 : rdata_front);
		result.rear_value  = stat_s1.empty ? '1 : (fwd_rear_s1 ? wdata_s1 : rdata_rear);
	end

	// a transfer is answered in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("command transfer without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without a command transfer");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$past(cfg_wr) |-> result.occupancy <= cap_eff)
		else $error("occupancy above capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.empty_res == (result.occupancy == '0)))
		else $error("empty flag disagrees with occupancy");

endmodule
